[hdl/lse_pkg.sv]
`default_nettype none
package lse_pkg;

  // Stack geometry
  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ENT_W  = 6;

  // Opcodes
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_POP     = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_REMOVE  = 3'd3;
  localparam logic [2:0] OP_REPLACE = 3'd4;
  localparam logic [2:0] OP_REVERSE = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNDER    = 2'd1;
  localparam logic [1:0] ST_OVER     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_RDK,
    S_SWAP_A,
    S_SWAP_B,
    S_EMIT,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

[hdl/lifo_stack_engine_unit.sv]
// LIFO stack engine: a bounded stack of DEPTH signed words held in a
// single-port-write, single-port-read memory with registered read data.
// Input channel (in_valid/in_stall): one item per operation (push, pop,
// read all, remove matching, replace matching, reverse). in_stall is high
// whenever the sequencer is busy; a new item is taken only from idle.
// Result channel (out_valid/out_stall): one result per item, or one per
// entry for read all (top down, last set on the bottom entry).
// Steps, each entry walk using one memory read a step and one shared
// word comparator:
//   push, unused opcodes, empty stack: straight to the result step
//   pop: read, check, then result
//   read all: read, check and emit for each entry, top down
//   remove, replace: read and check for each entry, then result
//   reverse: read, check, read top, two swap writes per pair, then result
// A waiting result sits in the output register; the block still accepts
// the next item and holds back its first result until that register frees.
// A stall on a waiting result freezes the sequencer at its emit or finish step.
// Synchronous reset empties the stack and drops any pending result; memory
// contents are not cleared and are never used above the entry count.
`default_nettype none
module lifo_stack_engine_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_opcode,
  input  wire logic signed [31:0]       in_value,
  input  wire logic signed [31:0]       in_new_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic signed [31:0]            out_data,
  output logic                          out_last,
  output logic [lse_pkg::ENT_W-1:0]     out_entries
);
  import lse_pkg::*;

  // Control and datapath registers
  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  word_t             key_r, key_nxt;
  word_t             nval_r, nval_nxt;
  word_t             data_r, data_nxt;
  word_t             tmp_r, tmp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              hit_r, hit_nxt;
  logic [1:0]        stat_r, stat_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  word_t             out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic [ENT_W-1:0]  out_entries_r, out_entries_nxt;

  // Memory
  word_t             mem [DEPTH];
  word_t             rdata_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  word_t             mem_wd;
  logic [IDX_W-1:0]  mem_ra;

  logic              in_fire;
  logic              out_free;
  logic              walk_end;
  logic              match;
  logic [CNT_W-1:0]  j_inc;
  logic              more_pairs;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Shared comparator and loop bounds
  assign match      = (rdata_r == key_r);
  assign walk_end   = (i_r == cnt_r - CNT_W'(1));
  assign j_inc      = j_r + CNT_W'(1);
  assign more_pairs = ((i_r + CNT_W'(1)) < (k_r - CNT_W'(1)));
  assign mem_ra     = (state_r == S_RDK) ? k_r[IDX_W-1:0] : i_r[IDX_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_opcode == OP_PUSH || in_opcode > OP_REVERSE || cnt_r == '0) begin
            state_nxt = S_FIN;
          end else if (in_opcode == OP_REVERSE && cnt_r == CNT_W'(1)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        case (op_r) inside
          OP_READ:               state_nxt = S_EMIT;
          OP_REMOVE, OP_REPLACE: state_nxt = walk_end ? S_FIN : S_RD;
          OP_REVERSE:            state_nxt = S_RDK;
          default:               state_nxt = S_FIN;
        endcase
      end
      S_RDK:    state_nxt = S_SWAP_A;
      S_SWAP_A: state_nxt = S_SWAP_B;
      S_SWAP_B: state_nxt = more_pairs ? S_RD : S_FIN;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = (i_r == '0) ? S_IDLE : S_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory port and output register controls
  always_comb begin
    op_nxt          = op_r;
    key_nxt         = key_r;
    nval_nxt        = nval_r;
    data_nxt        = data_r;
    tmp_nxt         = tmp_r;
    cnt_nxt         = cnt_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    k_nxt           = k_r;
    hit_nxt         = hit_r;
    stat_nxt        = stat_r;
    mem_we          = 1'b0;
    mem_wa          = i_r[IDX_W-1:0];
    mem_wd          = rdata_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    out_entries_nxt = out_entries_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_opcode;
          key_nxt  = in_value;
          nval_nxt = in_new_value;
          data_nxt = '0;
          hit_nxt  = 1'b0;
          i_nxt    = '0;
          j_nxt    = '0;
          k_nxt    = cnt_r - CNT_W'(1);
          stat_nxt = ST_OK;
          if (in_opcode == OP_PUSH) begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              stat_nxt = ST_OVER;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = cnt_r[IDX_W-1:0];
              mem_wd  = in_value;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else if (in_opcode > OP_REVERSE) begin
            stat_nxt = ST_OK;
          end else if (cnt_r == '0) begin
            stat_nxt = ST_UNDER;
          end else if (in_opcode == OP_POP) begin
            i_nxt   = cnt_r - CNT_W'(1);
            cnt_nxt = cnt_r - CNT_W'(1);
          end else if (in_opcode == OP_READ) begin
            i_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      S_RD: ;
      S_CHK: begin
        case (op_r) inside
          OP_POP, OP_READ: data_nxt = rdata_r;
          OP_REMOVE: begin
            if (!match) begin
              mem_we = 1'b1;
              mem_wa = j_r[IDX_W-1:0];
              mem_wd = rdata_r;
              j_nxt  = j_inc;
            end
            if (walk_end) begin
              cnt_nxt  = match ? j_r : j_inc;
              stat_nxt = ((match ? j_r : j_inc) != cnt_r) ? ST_OK : ST_NOTFOUND;
            end else begin
              i_nxt = i_r + CNT_W'(1);
            end
          end
          OP_REPLACE: begin
            if (match) begin
              mem_we  = 1'b1;
              mem_wd  = nval_r;
              hit_nxt = 1'b1;
            end
            if (walk_end) begin
              stat_nxt = (hit_r || match) ? ST_OK : ST_NOTFOUND;
            end else begin
              i_nxt = i_r + CNT_W'(1);
            end
          end
          OP_REVERSE: tmp_nxt = rdata_r;
          default: ;
        endcase
      end
      S_RDK: ;
      S_SWAP_A: begin
        // top word goes to the lower slot
        mem_we = 1'b1;
        mem_wd = rdata_r;
      end
      S_SWAP_B: begin
        mem_we = 1'b1;
        mem_wa = k_r[IDX_W-1:0];
        mem_wd = tmp_r;
        i_nxt  = i_r + CNT_W'(1);
        k_nxt  = k_r - CNT_W'(1);
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_data_nxt    = data_r;
          out_last_nxt    = (i_r == '0);
          out_entries_nxt = ENT_W'(cnt_r);
          if (i_r != '0) begin
            i_nxt = i_r - CNT_W'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = stat_r;
          out_data_nxt    = data_r;
          out_last_nxt    = 1'b1;
          out_entries_nxt = ENT_W'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  // Stack memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    nval_r        <= nval_nxt;
    data_r        <= data_nxt;
    tmp_r         <= tmp_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    k_r           <= k_nxt;
    hit_r         <= hit_nxt;
    stat_r        <= stat_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_last_r    <= out_last_nxt;
    out_entries_r <= out_entries_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_data    = out_data_r;
  assign out_last    = out_last_r;
  assign out_entries = out_entries_r;

endmodule
`default_nettype wire

[sim/lse_checker.sv]
`timescale 1ns / 100ps

module lse_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [2:0]              in_opcode,
  input  logic signed [31:0]      in_value,
  input  logic signed [31:0]      in_new_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [1:0]              out_status,
  input  logic signed [31:0]      out_data,
  input  logic                    out_last,
  input  logic [lse_pkg::ENT_W-1:0] out_entries,
  output int                      err_count,
  output int                      outstanding,
  output int                      results_checked,
  output int                      overflow_seen
);
  import lse_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    word_t            data;
    logic             last;
    logic [ENT_W-1:0] entries;
  } stack_result_t;

  // Shadow of the stack: index 0 is the bottom
  word_t         shadow_words [DEPTH];
  int            shadow_depth;
  stack_result_t pending_results [$];
  stack_result_t oldest;

  initial begin
    err_count       = 0;
    outstanding     = 0;
    results_checked = 0;
    overflow_seen   = 0;
    shadow_depth    = 0;
  end

  function automatic void queue_result(logic [1:0] status, word_t data, logic last);
    stack_result_t r;
    r.status  = status;
    r.data    = data;
    r.last    = last;
    r.entries = ENT_W'(shadow_depth);
    pending_results.push_back(r);
  endfunction

  // Work out the results of one accepted item and update the shadow stack
  function automatic void apply_stack_op(logic [2:0] op, word_t key, word_t subst);
    int    keep;
    bit    hit;
    word_t tmp;
    if (op == OP_PUSH) begin
      if (shadow_depth >= DEPTH) begin
        overflow_seen++;
        queue_result(ST_OVER, '0, 1'b1);
      end else begin
        shadow_words[shadow_depth] = key;
        shadow_depth++;
        queue_result(ST_OK, '0, 1'b1);
      end
    end else if (op > OP_REVERSE) begin
      // spare opcodes leave the stack alone
      queue_result(ST_OK, '0, 1'b1);
    end else if (shadow_depth == 0) begin
      queue_result(ST_UNDER, '0, 1'b1);
    end else begin
      case (op)
        OP_POP: begin
          shadow_depth--;
          queue_result(ST_OK, shadow_words[shadow_depth], 1'b1);
        end
        OP_READ: begin
          for (int i = shadow_depth - 1; i >= 0; i--)
            queue_result(ST_OK, shadow_words[i], i == 0);
        end
        OP_REMOVE: begin
          // compact survivors downwards, order kept
          keep = 0;
          for (int i = 0; i < shadow_depth; i++) begin
            if (shadow_words[i] != key) begin
              shadow_words[keep] = shadow_words[i];
              keep++;
            end
          end
          hit = (keep != shadow_depth);
          shadow_depth = keep;
          queue_result(hit ? ST_OK : ST_NOTFOUND, '0, 1'b1);
        end
        OP_REPLACE: begin
          hit = 1'b0;
          for (int i = 0; i < shadow_depth; i++) begin
            if (shadow_words[i] == key) begin
              shadow_words[i] = subst;
              hit = 1'b1;
            end
          end
          queue_result(hit ? ST_OK : ST_NOTFOUND, '0, 1'b1);
        end
        default: begin
          for (int i = 0; i < shadow_depth / 2; i++) begin
            tmp = shadow_words[i];
            shadow_words[i] = shadow_words[shadow_depth - 1 - i];
            shadow_words[shadow_depth - 1 - i] = tmp;
          end
          queue_result(ST_OK, '0, 1'b1);
        end
      endcase
    end
  endfunction

  // Results are compared before the item of the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_depth = 0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d data %0d last %0d entries %0d",
                 out_status, out_data, out_last, out_entries);
          err_count++;
        end else begin
          oldest = pending_results.pop_front();
          results_checked++;
          if (out_status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_status);
            err_count++;
          end
          if (out_data !== oldest.data) begin
            $error("data: expected %0d, got %0d", oldest.data, out_data);
            err_count++;
          end
          if (out_last !== oldest.last) begin
            $error("last: expected %0d, got %0d", oldest.last, out_last);
            err_count++;
          end
          if (out_entries !== oldest.entries) begin
            $error("entries: expected %0d, got %0d", oldest.entries, out_entries);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        apply_stack_op(in_opcode, in_value, in_new_value);
    end
    outstanding = pending_results.size();
  end

endmodule

[sim/tb_lifo_stack_engine_unit.sv]
`timescale 1ns / 100ps

module tb_lifo_stack_engine_unit;
  import lse_pkg::*;

  localparam int          HALF_PERIOD  = 10;
  localparam int          RANDOM_ITEMS = 480;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [2:0]          in_opcode    = OP_PUSH;
  logic signed [31:0]  in_value     = '0;
  logic signed [31:0]  in_new_value = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [1:0]          out_status;
  logic signed [31:0]  out_data;
  logic                out_last;
  logic [ENT_W-1:0]    out_entries;

  int          err_count;
  int          outstanding;
  int          results_checked;
  int          overflow_seen;
  int          op_counts [8];
  int unsigned cycle_count = 0;
  bit          steady_flow  = 1'b0;   // no gaps on either side
  bit          hold_request = 1'b0;   // ask the sink for one long hold-off

  // Words that often repeat, so remove and replace find matches
  word_t word_pool [8] = '{32'sh0000_0000, -32'sd1, 32'sh0000_0001, 32'sh7FFF_FFFF,
                           32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA,
                           32'sh1234_5678};

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  lifo_stack_engine_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_last     (out_last),
    .out_entries  (out_entries)
  );

  lse_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data        (out_data),
    .out_last        (out_last),
    .out_entries     (out_entries),
    .err_count       (err_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .overflow_seen   (overflow_seen)
  );

  function automatic word_t pick_word();
    if ($urandom_range(0, 3) != 0)
      return word_pool[$urandom_range(0, 7)];
    return word_t'($urandom());
  endfunction

  function automatic logic [2:0] pick_opcode(int push_pct);
    int r;
    if ($urandom_range(0, 99) < push_pct)
      return OP_PUSH;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_POP;
    if (r < 55) return OP_READ;
    if (r < 70) return OP_REMOVE;
    if (r < 85) return OP_REPLACE;
    if (r < 97) return OP_REVERSE;
    return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(logic [2:0] op, word_t key, word_t subst);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_value     <= key;
    in_new_value <= subst;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    op_counts[op]++;
  endtask

  // Result sink: random stall per item, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = steady_flow ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Stimulus
  initial begin : stimulus
    int          seg_len;
    int          push_pct;
    int          real_items;
    logic [2:0]  op;
    bit          first_seg;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every operation on an empty stack, spare opcodes included
    send_item(OP_POP, '0, '0);
    send_item(OP_READ, '0, '0);
    send_item(OP_REMOVE, '0, '0);
    send_item(OP_REPLACE, '0, 32'sh1);
    send_item(OP_REVERSE, '0, '0);
    send_item(OP_SPARE_LO, 32'sh7FFF_FFFF, -32'sd1);
    send_item(OP_SPARE_HI, 32'sh8000_0000, '0);
    // extremes, with a duplicated zero
    send_item(OP_PUSH, 32'sh7FFF_FFFF, '0);
    send_item(OP_PUSH, 32'sh8000_0000, '0);
    send_item(OP_PUSH, 32'sh0000_0000, '0);
    send_item(OP_PUSH, -32'sd1, '0);
    send_item(OP_PUSH, 32'sh0000_0000, '0);
    send_item(OP_READ, '0, '0);
    // replace both zeros, then a key that is absent
    send_item(OP_REPLACE, 32'sh0000_0000, 32'sh5555_5555);
    send_item(OP_REPLACE, 32'sh1234_5678, 32'shAAAA_AAAA);
    // remove both copies, then remove a key that is absent
    send_item(OP_REMOVE, 32'sh5555_5555, '0);
    send_item(OP_REMOVE, 32'sh0BAD_F00D, '0);
    // odd count reverse, then read back
    send_item(OP_REVERSE, '0, '0);
    send_item(OP_READ, '0, '0);
    send_item(OP_SPARE_HI, -32'sd1, -32'sd1);
    send_item(OP_POP, '0, '0);
    send_item(OP_POP, '0, '0);

    // long hold-off on the result side while items keep coming
    hold_request = 1'b1;
    steady_flow  = 1'b1;
    repeat (12) send_item(OP_PUSH, pick_word(), '0);
    steady_flow  = 1'b0;

    // random segments with varying push bias; the first one is mostly pushes
    real_items = 0;
    first_seg  = 1'b1;
    while (real_items < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 48);
      if (first_seg || $urandom_range(0, 3) == 0)
        push_pct = 95;
      else
        push_pct = $urandom_range(15, 85);
      first_seg   = 1'b0;
      steady_flow = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len && real_items < RANDOM_ITEMS; k++) begin
        op = pick_opcode(push_pct);
        send_item(op, pick_word(), pick_word());
        if (op <= OP_REVERSE)
          real_items++;
      end
    end
    in_valid    <= 1'b0;
    steady_flow  = 1'b0;

    // let the checker register the last item, drain, then watch for strays
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered push %0d, pop %0d, read-out %0d, remove %0d, replace %0d,",
             op_counts[OP_PUSH], op_counts[OP_POP], op_counts[OP_READ],
             op_counts[OP_REMOVE], op_counts[OP_REPLACE]);
    $display("  reverse %0d, spare %0d items; %0d results checked, %0d full-stack pushes",
             op_counts[OP_REVERSE], op_counts[OP_SPARE_LO] + op_counts[OP_SPARE_HI],
             results_checked, overflow_seen);
    if (err_count == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still expected",
             cycle_count, outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
